>>> src/bfiq_pkg.sv
// Package for the Bloom filter insert/query block: types, constants, hash helpers.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
package bfiq_pkg;

    localparam int MAX_FILTER_BYTES_C = 32768;
    localparam int MAX_KEY_BYTES_C    = 520;
    localparam int MAX_HASHES_C       = 50;

    localparam logic [31:0] SEED_STEP = 32'hFBA4C795;
    localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2     = 32'h1b873593;
    localparam logic [31:0] MM_ADD    = 32'he6546b64;
    localparam logic [31:0] MM_F1     = 32'h85ebca6b;
    localparam logic [31:0] MM_F2     = 32'hc2b2ae35;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_SCAN   = 2'd3;

    localparam logic [1:0] REG_NUM_HASHES   = 2'd0;
    localparam logic [1:0] REG_HASH_TWEAK   = 2'd1;
    localparam logic [1:0] REG_FILTER_BYTES = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] key_byte;
        logic       key_last;
    } bfiq_in_t;

    typedef struct packed {
        logic found;
        logic filter_empty;
        logic filter_full;
        logic key_truncated;
    } bfiq_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } bfiq_cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN,
        ST_H_INIT,
        ST_H_RD,
        ST_H_WAIT,
        ST_H_BLK1,
        ST_H_BLK2,
        ST_H_BLK3,
        ST_H_TAIL,
        ST_H_F1,
        ST_H_F2,
        ST_H_F3,
        ST_MOD,
        ST_PROBE_RD,
        ST_PROBE,
        ST_OUT
    } bfiq_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

>>> src/bloom_filter_insert_query.sv
// Channel | direction | signals
// in      | in        | in_valid, in_stall (out), in_data
// out     | out       | out_valid, out_stall (in), out_data
// cfg     | in        | cfg_valid, cfg_ready (out), cfg_data
// Non-last key bytes are only stored in the key buffer. For a last byte, each probe hashes
// the key: one key byte read per cycle, three multiply and mix steps per four bytes, three
// finishing steps, a bit-serial remainder and a store read-modify-write. Clear sweeps all
// store bytes and scan reads the bytes in use, one a cycle. After reset a clearing pass
// over all MAX_FILTER_BYTES store bytes zeroes the store. The output register holds a
// result until taken; key bytes are still accepted meanwhile, and a new result waits in
// its final state for the register.
// Top level of the Bloom filter block; depends on bfiq_pkg, bfiq_store, bfiq_keybuf.
`timescale 1ns / 1ps
module bloom_filter_insert_query #(
    parameter int MAX_FILTER_BYTES = bfiq_pkg::MAX_FILTER_BYTES_C,
    parameter int MAX_KEY_BYTES    = bfiq_pkg::MAX_KEY_BYTES_C,
    parameter int MAX_HASHES       = bfiq_pkg::MAX_HASHES_C
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bfiq_pkg::bfiq_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bfiq_pkg::bfiq_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bfiq_pkg::bfiq_cfg_t cfg_data
);
    import bfiq_pkg::*;

    localparam int SAW = $clog2(MAX_FILTER_BYTES) > 0 ? $clog2(MAX_FILTER_BYTES) : 1;
    localparam int KAW = $clog2(MAX_KEY_BYTES) > 0 ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
    localparam int SCW = $clog2(MAX_FILTER_BYTES + 1);
    localparam int MW  = SCW + 3;
    localparam int HCW = 6;

    bfiq_state_t state_reg, state_next;

    logic [5:0]  num_hashes_reg;
    logic [31:0] hash_tweak_reg;
    logic [15:0] filter_bytes_reg;

    logic            empty_reg, full_reg, overflow_reg;
    logic [KLW-1:0]  klen_reg;
    logic [SCW-1:0]  sweep_reg;
    logic            init_done_reg;
    logic            fe_reg, ff_reg;

    logic [1:0]      op_reg;
    logic [HCW-1:0]  hidx_reg;
    logic [HCW-1:0]  hcount_reg;
    logic [31:0]     seed_reg, h_reg, k_reg;
    logic [KLW-1:0]  pos_reg;
    logic [1:0]      lane_reg;
    logic [31:0]     rem_reg;
    logic [5:0]      mbit_reg;
    logic [MW-1:0]   bitidx_reg;
    logic            found_reg, trunc_reg;

    logic            out_valid_reg;
    bfiq_out_t       out_reg;

    logic [7:0]      st_rdata, kb_rdata;
    logic [SAW-1:0]  st_raddr, st_waddr;
    logic [7:0]      st_wdata;
    logic            st_we;
    logic [KAW-1:0]  kb_raddr;
    logic            kb_we;

    logic            accept;
    logic [SCW-1:0]  used_bytes;
    logic [MW-1:0]   modulus;
    logic [HCW-1:0]  probe_n;
    logic [31:0]     mult_a, mult_b, mult_p;
    logic [32:0]     rem_sh;
    logic [MW:0]     rem_try;
    logic [7:0]      bit_mask;

    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || !init_done_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (filter_bytes_reg == 16'd0)
        begin
            used_bytes = SCW'(1);
        end
        else if (32'(filter_bytes_reg) > 32'(MAX_FILTER_BYTES))
        begin
            used_bytes = SCW'(MAX_FILTER_BYTES);
        end
        else
        begin
            used_bytes = SCW'(filter_bytes_reg);
        end
        modulus = {used_bytes, 3'b000};
        probe_n = (32'(num_hashes_reg) > 32'(MAX_HASHES)) ? HCW'(MAX_HASHES) : num_hashes_reg;
        bit_mask = 8'd1 << bitidx_reg[2:0];
    end

    // One shared 32x32 multiplier; operands picked by the hash step.
    always_comb
    begin
        mult_a = k_reg;
        mult_b = MM_C1;
        unique case (state_reg)
            ST_H_BLK1:           begin mult_a = k_reg; mult_b = MM_C1; end
            ST_H_BLK2:           begin mult_a = rotl(k_reg, 15); mult_b = MM_C2; end
            ST_H_F1:             begin mult_a = h_reg ^ (h_reg >> 16); mult_b = MM_F1; end
            ST_H_F2:             begin mult_a = h_reg ^ (h_reg >> 13); mult_b = MM_F2; end
            default:             begin mult_a = k_reg; mult_b = MM_C1; end
        endcase
        mult_p = mult_a * mult_b;
    end

    // Restoring remainder, one hash bit per cycle.
    always_comb
    begin
        rem_sh  = {rem_reg[31:0], h_reg[31]};
        rem_try = (MW+1)'(rem_sh) - {1'b0, modulus};
    end

    bfiq_store #(.FILTER_BYTES(MAX_FILTER_BYTES), .AW(SAW)) u_store (
        .clk(clk), .rd_addr(st_raddr), .rd_data(st_rdata),
        .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata)
    );

    bfiq_keybuf #(.KEY_BYTES(MAX_KEY_BYTES), .AW(KAW)) u_keybuf (
        .clk(clk), .wr_en(kb_we), .wr_addr(klen_reg[KAW-1:0]), .wr_data(in_data.key_byte),
        .rd_addr(kb_raddr), .rd_data(kb_rdata)
    );

    assign kb_we = accept && (in_data.func == FUNC_INSERT || in_data.func == FUNC_QUERY)
                   && (32'(klen_reg) < 32'(MAX_KEY_BYTES));
    assign kb_raddr = pos_reg[KAW-1:0];

    always_comb
    begin
        st_raddr = sweep_reg[SAW-1:0];
        st_we    = 1'b0;
        st_waddr = sweep_reg[SAW-1:0];
        st_wdata = 8'd0;
        if (!init_done_reg || state_reg == ST_CLEAR)
        begin
            st_we = 1'b1;
        end
        if (state_reg == ST_PROBE_RD || state_reg == ST_PROBE)
        begin
            st_raddr = bitidx_reg[SAW+2:3];
            st_waddr = bitidx_reg[SAW+2:3];
        end
        if (state_reg == ST_PROBE && op_reg == FUNC_INSERT)
        begin
            st_we    = 1'b1;
            st_wdata = st_rdata | bit_mask;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.func)
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        FUNC_SCAN:  state_next = ST_SCAN_RD;
                        default:
                        begin
                            if (in_data.key_last)
                            begin
                                state_next = ST_H_INIT;
                            end
                        end
                    endcase
                end
            end
            ST_CLEAR:
                if (32'(sweep_reg) == 32'(MAX_FILTER_BYTES - 1)) state_next = ST_OUT;
            ST_SCAN_RD: state_next = ST_SCAN;
            ST_SCAN:
                if (sweep_reg == used_bytes) state_next = ST_OUT;
            ST_H_INIT:
            begin
                if (hidx_reg == hcount_reg) state_next = ST_OUT;
                else state_next = ST_H_RD;
            end
            ST_H_RD:
            begin
                if (32'(pos_reg) + 32'd1 >= 32'(klen_reg) || 32'(klen_reg) == 0)
                begin
                    state_next = (klen_reg == '0) ? ST_H_TAIL : ST_H_WAIT;
                end
                else
                begin
                    state_next = ST_H_WAIT;
                end
            end
            ST_H_WAIT:
            begin
                // A partial last block goes through the same multiply steps as a full one.
                if (lane_reg == 2'd3 || pos_reg == klen_reg) state_next = ST_H_BLK1;
                else state_next = ST_H_WAIT;
            end
            ST_H_BLK1: state_next = ST_H_BLK2;
            ST_H_BLK2: state_next = ST_H_BLK3;
            ST_H_BLK3:
            begin
                if (lane_reg != 2'd0) state_next = ST_H_F1;
                else state_next = (pos_reg == klen_reg) ? ST_H_TAIL : ST_H_WAIT;
            end
            ST_H_TAIL: state_next = ST_H_F1;
            ST_H_F1:   state_next = ST_H_F2;
            ST_H_F2:   state_next = ST_H_F3;
            ST_H_F3:   state_next = ST_MOD;
            ST_MOD:
                if (mbit_reg == 6'd31) state_next = ST_PROBE_RD;
            ST_PROBE_RD: state_next = ST_PROBE;
            ST_PROBE:    state_next = ST_H_INIT;
            ST_OUT:
                if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            num_hashes_reg   <= 6'd1;
            hash_tweak_reg   <= 32'd0;
            filter_bytes_reg <= 16'd32768;
            empty_reg        <= 1'b1;
            full_reg         <= 1'b0;
            overflow_reg     <= 1'b0;
            klen_reg         <= '0;
            sweep_reg        <= '0;
            init_done_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_data.index)
                    REG_NUM_HASHES:   num_hashes_reg   <= cfg_data.data[5:0];
                    REG_HASH_TWEAK:   hash_tweak_reg   <= cfg_data.data;
                    REG_FILTER_BYTES: filter_bytes_reg <= cfg_data.data[15:0];
                    default: ;
                endcase
            end
            if (!init_done_reg)
            begin
                if (32'(sweep_reg) == 32'(MAX_FILTER_BYTES - 1))
                begin
                    init_done_reg <= 1'b1;
                    sweep_reg     <= '0;
                end
                else
                begin
                    sweep_reg <= sweep_reg + SCW'(1);
                end
            end
            if (state_reg == ST_OUT && state_next == ST_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (kb_we)
            begin
                klen_reg <= klen_reg + KLW'(1);
            end
            else if (accept && (in_data.func == FUNC_INSERT || in_data.func == FUNC_QUERY))
            begin
                overflow_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                    if (accept) sweep_reg <= '0;
                ST_CLEAR:
                begin
                    sweep_reg <= sweep_reg + SCW'(1);
                    if (state_next == ST_OUT)
                    begin
                        empty_reg <= 1'b1;
                        full_reg  <= 1'b0;
                    end
                end
                ST_SCAN_RD: sweep_reg <= sweep_reg + SCW'(1);
                ST_SCAN:
                begin
                    sweep_reg <= sweep_reg + SCW'(1);
                    if (state_next == ST_OUT)
                    begin
                        full_reg  <= ff_reg && (st_rdata == 8'hFF);
                        empty_reg <= fe_reg && (st_rdata == 8'h00);
                    end
                end
                ST_PROBE:
                begin
                    if (op_reg == FUNC_INSERT) empty_reg <= 1'b0;
                end
                ST_H_INIT:
                begin
                    if (state_next == ST_OUT && op_reg == FUNC_INSERT && !full_reg)
                    begin
                        empty_reg <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    if (state_next == ST_IDLE
                        && (op_reg == FUNC_INSERT || op_reg == FUNC_QUERY))
                    begin
                        klen_reg     <= '0;
                        overflow_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_reg    <= in_data.func;
                    hidx_reg  <= '0;
                    fe_reg    <= 1'b1;
                    ff_reg    <= 1'b1;
                    trunc_reg <= kb_we ? overflow_reg : 1'b1;
                    found_reg <= 1'b0;
                    if (in_data.func == FUNC_QUERY)
                    begin
                        found_reg <= full_reg || !empty_reg;
                    end
                    // Full filter: insert does nothing; query answer is fixed, as for a query of an empty filter.
                    if (full_reg || (in_data.func == FUNC_QUERY && empty_reg))
                    begin
                        hcount_reg <= '0;
                    end
                    else
                    begin
                        hcount_reg <= probe_n;
                    end
                    seed_reg <= hash_tweak_reg;
                end
            end
            ST_SCAN:
            begin
                ff_reg <= ff_reg && (st_rdata == 8'hFF);
                fe_reg <= fe_reg && (st_rdata == 8'h00);
            end
            ST_H_INIT:
            begin
                h_reg    <= seed_reg;
                k_reg    <= '0;
                pos_reg  <= '0;
                lane_reg <= 2'd0;
            end
            ST_H_RD:
            begin
                if (klen_reg != '0) pos_reg <= pos_reg + KLW'(1);
            end
            ST_H_WAIT:
            begin
                k_reg <= k_reg | (32'(kb_rdata) << {lane_reg, 3'b000});
                lane_reg <= lane_reg + 2'd1;
                if (lane_reg != 2'd3 && pos_reg != klen_reg)
                begin
                    pos_reg <= pos_reg + KLW'(1);
                end
            end
            ST_H_BLK1: k_reg <= mult_p;
            ST_H_BLK2: k_reg <= mult_p;
            ST_H_BLK3:
            begin
                // A non-zero lane count marks the partial last block.
                if (lane_reg != 2'd0)
                begin
                    h_reg <= h_reg ^ k_reg ^ 32'(klen_reg);
                end
                else
                begin
                    h_reg <= rotl(h_reg ^ k_reg, 13) * 32'd5 + MM_ADD;
                end
                k_reg <= '0;
                if (pos_reg != klen_reg) pos_reg <= pos_reg + KLW'(1);
            end
            ST_H_TAIL:
            begin
                // No bytes remain past the last full block.
                h_reg <= h_reg ^ 32'(klen_reg);
            end
            ST_H_F1: h_reg <= mult_p;
            ST_H_F2: h_reg <= mult_p;
            ST_H_F3:
            begin
                h_reg    <= h_reg ^ (h_reg >> 16);
                rem_reg  <= '0;
                mbit_reg <= '0;
            end
            ST_MOD:
            begin
                h_reg    <= {h_reg[30:0], 1'b0};
                mbit_reg <= mbit_reg + 6'd1;
                if (!rem_try[MW]) rem_reg <= 32'(rem_try[MW-1:0]);
                else rem_reg <= rem_sh[31:0];
                if (mbit_reg == 6'd31)
                begin
                    bitidx_reg <= !rem_try[MW] ? rem_try[MW-1:0] : rem_sh[MW-1:0];
                end
            end
            ST_PROBE:
            begin
                hidx_reg <= hidx_reg + HCW'(1);
                seed_reg <= seed_reg + SEED_STEP;
                if (op_reg == FUNC_QUERY && (st_rdata & bit_mask) == 8'd0)
                begin
                    found_reg  <= 1'b0;
                    hcount_reg <= hidx_reg + HCW'(1);
                end
            end
            ST_OUT:
            begin
                if (state_next == ST_IDLE)
                begin
                    out_reg.found         <= (op_reg == FUNC_QUERY) ? found_reg : 1'b0;
                    out_reg.filter_empty  <= empty_reg;
                    out_reg.filter_full   <= full_reg;
                    out_reg.key_truncated <= (op_reg == FUNC_INSERT || op_reg == FUNC_QUERY)
                                             ? trunc_reg : 1'b0;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> src/bfiq_store.sv
// Bit store of the filter: one synchronous byte memory with a registered read.
// Depends on bfiq_pkg.
`timescale 1ns / 1ps
module bfiq_store #(
    parameter int FILTER_BYTES = bfiq_pkg::MAX_FILTER_BYTES_C,
    parameter int AW = $clog2(FILTER_BYTES) > 0 ? $clog2(FILTER_BYTES) : 1
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);
    import bfiq_pkg::*;

    logic [7:0] mem [FILTER_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> src/bfiq_keybuf.sv
// Key byte buffer: one synchronous memory, written per byte, read per byte.
// Depends on bfiq_pkg.
`timescale 1ns / 1ps
module bfiq_keybuf #(
    parameter int KEY_BYTES = bfiq_pkg::MAX_KEY_BYTES_C,
    parameter int AW = $clog2(KEY_BYTES) > 0 ? $clog2(KEY_BYTES) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    import bfiq_pkg::*;

    logic [7:0] mem [KEY_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> src/bfiq_checker.sv
// Port-level checks for the Bloom filter block, bound to the top level.
// Depends on bfiq_pkg and bloom_filter_insert_query.
`timescale 1ns / 1ps
module bfiq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input bfiq_pkg::bfiq_in_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input bfiq_pkg::bfiq_out_t out_data
);
    import bfiq_pkg::*;

    // A stalled input item stays offered and unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input item changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Flags are never both set.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.filter_empty && out_data.filter_full))
        else $error("empty and full together");

    // A query of an empty filter never reports found.
    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> !out_data.filter_empty)
        else $error("found on empty filter");
endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
